// ----- hdl/bnk_pkg.sv -----
// Package for the banker safety and request check unit.
// Holds op, status and state codes; used by the interfaces, the top module and the checker.
package bnk_pkg;

   localparam int OP_BITS     = 3;
   localparam int IDX_BITS    = 4;
   localparam int AMT_BITS    = 8;
   localparam int STATUS_BITS = 2;
   localparam int CFG_BITS    = 5;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD_ALLOC = 3'd0,
      OP_LOAD_MAX   = 3'd1,
      OP_LOAD_AVAIL = 3'd2,
      OP_SAFETY     = 3'd3,
      OP_REQUEST    = 3'd4
   } op_type;

   localparam logic [STATUS_BITS-1:0] ST_GRANTED = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EXCEEDS = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_UNSAFE  = 2'd2;

   localparam logic [0:0] KIND_SAFETY  = 1'b0;
   localparam logic [0:0] KIND_REQUEST = 1'b1;

   localparam logic [0:0] REG_NUM_PROCESSES = 1'b0;
   localparam logic [0:0] REG_NUM_RESOURCES = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RQ_RD,      // read alloc entry j for request check
      S_RQ_CHK,
      S_RQ_APPLY_RD,
      S_RQ_APPLY,   // write alloc and available for resource j
      S_SF_INIT,    // copy available into work, one resource a cycle
      S_SF_PROC,    // start testing process i
      S_SF_RD,      // read max/alloc entry
      S_SF_FIT,     // compare need against work
      S_SF_ADD_RD,
      S_SF_ADD,     // add allocation to work
      S_SF_NEXT,
      S_SF_DONE,
      S_RB_RD,      // roll back request
      S_RB,
      S_EMIT,
      S_EMIT_WAIT
   } state_type;

endpackage

// ----- hdl/bnk_if.sv -----
// Valid/ready channel interfaces for the banker unit.
// Depends on bnk_pkg.
interface bnk_req_if;
   logic                         valid;
   logic                         ready;
   logic [bnk_pkg::OP_BITS-1:0]  op;
   logic [bnk_pkg::IDX_BITS-1:0] process;
   logic [bnk_pkg::IDX_BITS-1:0] resource;
   logic [bnk_pkg::AMT_BITS-1:0] amount;
   logic                         last;
   modport source (output valid, op, process, resource, amount, last, input ready);
   modport sink   (input valid, op, process, resource, amount, last, output ready);
endinterface

interface bnk_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic                            safe;
   logic [bnk_pkg::IDX_BITS-1:0]    order_process;
   logic [bnk_pkg::STATUS_BITS-1:0] status;
   logic                            end_of_run;
   modport source (output valid, kind, safe, order_process, status, end_of_run,
                   input ready);
   modport sink   (input valid, kind, safe, order_process, status, end_of_run,
                   output ready);
endinterface

// ----- hdl/bnk_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module bnk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- hdl/banker_safety_and_request_check.sv -----
// Banker's algorithm unit: table loads, safety check with finishing order, and request
// verdicts. A safety check first copies available into work, then walks the processes
// with one shared compare/add unit. A process already finished is skipped. For a process
// under test each resource's need is compared against work in turn, and when it fits its
// allocation is added to work resource by resource. Passes repeat while one finishes a
// process, so there are at most P+1 passes for P processes. Result words then go out one
// per cycle unless the output stalls. A request verdict adds a check, an apply, the safety
// run and, when unsafe, a rollback. The block takes no new word while one is in progress.
// Allocation and maximum tables sit in RAMs read one entry at a time; that single read
// port sets the pace.
// Depends on bnk_pkg, bnk_if and bnk_ram.
module banker_safety_and_request_check #(
   parameter int MAX_PROCESSES = 16,
   parameter int MAX_RESOURCES = 16,
   parameter int COUNT_BITS    = 8
) (
   input  logic        clock,
   input  logic        reset,
   bnk_req_if.sink     req,
   bnk_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int PB = $clog2(MAX_PROCESSES);
   localparam int RB = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int AB = PB + RB;
   localparam int DEPTH = MAX_PROCESSES * (1 << RB);
   localparam int WB = COUNT_BITS + 4;
   localparam int PCAP = (MAX_PROCESSES < 16) ? MAX_PROCESSES : 16;
   localparam logic [WB-1:0] WORK_MAX = {WB{1'b1}};
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   // configuration
   logic [4:0] nproc_ff, nres_ff;
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         nproc_ff <= 5'd1;
         nres_ff  <= 5'd1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == bnk_pkg::REG_NUM_PROCESSES[0]) nproc_ff <= csr_pwdata[4:0];
         else nres_ff <= csr_pwdata[4:0];
      end
   end
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == bnk_pkg::REG_NUM_RESOURCES[0]) csr_prdata[4:0] = nres_ff;
      else csr_prdata[4:0] = nproc_ff;
   end

   // counts in use, minus one
   logic [PB-1:0] nlast;
   logic [RB-1:0] mlast;
   always_comb begin
      if (nproc_ff == 5'd0) nlast = '0;
      else if (32'(nproc_ff) > PCAP) nlast = PB'(PCAP - 1);
      else nlast = PB'(nproc_ff - 5'd1);
      if (nres_ff == 5'd0) mlast = '0;
      else if (32'(nres_ff) > MAX_RESOURCES) mlast = RB'(MAX_RESOURCES - 1);
      else mlast = RB'(nres_ff - 5'd1);
   end

   // small vectors in flops
   logic [COUNT_BITS-1:0] avail_ff [MAX_RESOURCES];
   logic [COUNT_BITS-1:0] rqv_ff   [MAX_RESOURCES];
   logic [WB-1:0]         work_ff  [MAX_RESOURCES];
   logic [MAX_PROCESSES-1:0] fin_ff;
   logic [3:0]            order_ff [16];

   bnk_pkg::state_type state_ff, state_in;
   logic [PB-1:0] i_ff, i_in;
   logic [RB-1:0] j_ff, j_in;
   logic [PB:0]   cnt_ff, cnt_in;   // finished count
   logic [4:0]    k_ff, k_in;       // emit index
   logic          prog_ff, prog_in, isreq_ff, isreq_in;
   logic [PB-1:0] rp_ff, rp_in;
   logic          rsafe_ff, rsafe_in;
   logic [1:0]    rst_ff, rst_in;

   // rams
   logic          al_we, mx_we;
   logic [AB-1:0] wa, ra;
   logic [COUNT_BITS-1:0] al_wd, mx_wd, al_q, mx_q;
   bnk_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_alloc (
      .clock(clock), .wr_en(al_we), .wr_addr(wa), .wr_data(al_wd),
      .rd_addr(ra), .rd_data(al_q));
   bnk_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_max (
      .clock(clock), .wr_en(mx_we), .wr_addr(wa), .wr_data(mx_wd),
      .rd_addr(ra), .rd_data(mx_q));

   logic acc;
   assign acc = req.valid && req.ready;
   assign req.ready = (state_ff == bnk_pkg::S_IDLE);

   logic [COUNT_BITS-1:0] amt;
   assign amt = COUNT_BITS'(req.amount > CMAX ? CMAX : req.amount);
   logic in_range_p, in_range_r;
   assign in_range_p = 32'(req.process) < MAX_PROCESSES;
   assign in_range_r = 32'(req.resource) < MAX_RESOURCES;

   // shared arithmetic
   logic signed [COUNT_BITS+1:0] need;
   logic [WB:0] wsum;
   logic [COUNT_BITS:0] asum;
   assign need = $signed({2'b0, mx_q}) - $signed({2'b0, al_q});
   assign wsum = {1'b0, work_ff[j_ff]} + (WB+1)'(al_q);
   assign asum = {1'b0, al_q} + {1'b0, rqv_ff[j_ff]};

   // vector update controls
   logic wk_load, wk_add, av_sub, av_add, av_wr, rq_wr, fin_clr, fin_set, ord_wr;

   always_comb begin
      state_in = state_ff; i_in = i_ff; j_in = j_ff; cnt_in = cnt_ff; k_in = k_ff;
      prog_in = prog_ff; isreq_in = isreq_ff; rp_in = rp_ff;
      rsafe_in = rsafe_ff; rst_in = rst_ff;
      al_we = 1'b0; mx_we = 1'b0; al_wd = amt; mx_wd = amt;
      wa = {PB'(req.process), RB'(req.resource)};
      ra = {i_ff, j_ff};
      wk_load = 1'b0; wk_add = 1'b0; av_sub = 1'b0; av_add = 1'b0; av_wr = 1'b0;
      rq_wr = 1'b0; fin_clr = 1'b0; fin_set = 1'b0; ord_wr = 1'b0;
      rsp.valid = 1'b0;
      unique case (state_ff)
         bnk_pkg::S_IDLE: begin
            if (acc) begin
               case (req.op)
                  bnk_pkg::OP_LOAD_ALLOC: al_we = in_range_p && in_range_r;
                  bnk_pkg::OP_LOAD_MAX:   mx_we = in_range_p && in_range_r;
                  bnk_pkg::OP_LOAD_AVAIL: av_wr = in_range_r;
                  bnk_pkg::OP_SAFETY: begin
                     isreq_in = 1'b0; j_in = '0; state_in = bnk_pkg::S_SF_INIT;
                  end
                  bnk_pkg::OP_REQUEST: begin
                     rq_wr = in_range_r;
                     if (req.last) begin
                        isreq_in = 1'b1; j_in = '0; i_in = PB'(req.process);
                        rp_in = PB'(req.process);
                        if (!in_range_p || PB'(req.process) > nlast ||
                            (MAX_PROCESSES < 16 && req.process >= 4'(MAX_PROCESSES))) begin
                           rsafe_in = 1'b0; rst_in = bnk_pkg::ST_EXCEEDS; k_in = '0;
                           state_in = bnk_pkg::S_EMIT;
                        end else state_in = bnk_pkg::S_RQ_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         bnk_pkg::S_RQ_RD: begin ra = {rp_ff, j_ff}; state_in = bnk_pkg::S_RQ_CHK; end
         bnk_pkg::S_RQ_CHK: begin
            if (rqv_ff[j_ff] > avail_ff[j_ff] || asum[COUNT_BITS]) begin
               rsafe_in = 1'b0; rst_in = bnk_pkg::ST_EXCEEDS; k_in = '0;
               state_in = bnk_pkg::S_EMIT;
            end else if (j_ff == mlast) begin
               j_in = '0; state_in = bnk_pkg::S_RQ_APPLY_RD;
            end else begin
               j_in = j_ff + 1'b1; state_in = bnk_pkg::S_RQ_RD;
            end
         end
         bnk_pkg::S_RQ_APPLY_RD: begin ra = {rp_ff, j_ff}; state_in = bnk_pkg::S_RQ_APPLY; end
         bnk_pkg::S_RQ_APPLY: begin
            wa = {rp_ff, j_ff}; al_we = 1'b1; al_wd = asum[COUNT_BITS-1:0]; av_sub = 1'b1;
            if (j_ff == mlast) begin j_in = '0; state_in = bnk_pkg::S_SF_INIT; end
            else begin j_in = j_ff + 1'b1; state_in = bnk_pkg::S_RQ_APPLY_RD; end
         end
         bnk_pkg::S_SF_INIT: begin
            wk_load = 1'b1; fin_clr = 1'b1;
            if (j_ff == RB'(MAX_RESOURCES - 1)) begin
               j_in = '0; i_in = '0; cnt_in = '0; prog_in = 1'b0;
               state_in = bnk_pkg::S_SF_PROC;
            end else j_in = j_ff + 1'b1;
         end
         bnk_pkg::S_SF_PROC: begin
            j_in = '0;
            state_in = fin_ff[i_ff] ? bnk_pkg::S_SF_NEXT : bnk_pkg::S_SF_RD;
         end
         bnk_pkg::S_SF_RD: state_in = bnk_pkg::S_SF_FIT;
         bnk_pkg::S_SF_FIT: begin
            // a negative need always fits
            if (!need[COUNT_BITS+1] && WB'(need[COUNT_BITS:0]) > work_ff[j_ff]) begin
               state_in = bnk_pkg::S_SF_NEXT;
            end else if (j_ff == mlast) begin
               j_in = '0; state_in = bnk_pkg::S_SF_ADD_RD;
            end else begin
               j_in = j_ff + 1'b1; state_in = bnk_pkg::S_SF_RD;
            end
         end
         bnk_pkg::S_SF_ADD_RD: state_in = bnk_pkg::S_SF_ADD;
         bnk_pkg::S_SF_ADD: begin
            wk_add = 1'b1;
            if (j_ff == mlast) begin
               fin_set = 1'b1; ord_wr = 1'b1; cnt_in = cnt_ff + 1'b1; prog_in = 1'b1;
               state_in = bnk_pkg::S_SF_NEXT;
            end else begin
               j_in = j_ff + 1'b1; state_in = bnk_pkg::S_SF_ADD_RD;
            end
         end
         bnk_pkg::S_SF_NEXT: begin
            if (i_ff == nlast) begin
               i_in = '0;
               if (prog_ff) begin prog_in = 1'b0; state_in = bnk_pkg::S_SF_PROC; end
               else state_in = bnk_pkg::S_SF_DONE;
            end else begin
               i_in = i_ff + 1'b1; state_in = bnk_pkg::S_SF_PROC;
            end
         end
         bnk_pkg::S_SF_DONE: begin
            k_in = '0;
            if (!isreq_ff) state_in = bnk_pkg::S_EMIT;
            else if (cnt_ff == (PB+1)'(nlast) + 1'b1) begin
               rsafe_in = 1'b1; rst_in = bnk_pkg::ST_GRANTED; state_in = bnk_pkg::S_EMIT;
            end else begin
               rsafe_in = 1'b0; rst_in = bnk_pkg::ST_UNSAFE; j_in = '0;
               state_in = bnk_pkg::S_RB_RD;
            end
         end
         bnk_pkg::S_RB_RD: begin ra = {rp_ff, j_ff}; state_in = bnk_pkg::S_RB; end
         bnk_pkg::S_RB: begin
            wa = {rp_ff, j_ff}; al_we = 1'b1; al_wd = al_q - rqv_ff[j_ff]; av_add = 1'b1;
            if (j_ff == mlast) state_in = bnk_pkg::S_EMIT;
            else begin j_in = j_ff + 1'b1; state_in = bnk_pkg::S_RB_RD; end
         end
         bnk_pkg::S_EMIT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               if (rsp.end_of_run) state_in = bnk_pkg::S_IDLE;
               else k_in = k_ff + 1'b1;
            end
         end
         default: state_in = bnk_pkg::S_IDLE;
      endcase
   end

   logic all_done;
   assign all_done = (cnt_ff == (PB+1)'(nlast) + 1'b1);
   always_comb begin
      rsp.order_process = '0; rsp.status = bnk_pkg::ST_GRANTED;
      if (isreq_ff) begin
         rsp.kind = bnk_pkg::KIND_REQUEST; rsp.safe = rsafe_ff; rsp.status = rst_ff;
         rsp.end_of_run = 1'b1;
      end else begin
         rsp.kind = bnk_pkg::KIND_SAFETY; rsp.safe = all_done;
         if (all_done) begin
            rsp.order_process = order_ff[k_ff[3:0]];
            rsp.end_of_run = (k_ff == 5'(nlast));
         end else rsp.end_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bnk_pkg::S_IDLE;
         isreq_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         isreq_ff <= isreq_in;
      end
      i_ff <= i_in; j_ff <= j_in; cnt_ff <= cnt_in; k_ff <= k_in;
      prog_ff <= prog_in; rp_ff <= rp_in;
      rsafe_ff <= rsafe_in; rst_ff <= rst_in;
      if (av_wr) avail_ff[RB'(req.resource)] <= amt;
      if (av_sub) avail_ff[j_ff] <= avail_ff[j_ff] - rqv_ff[j_ff];
      if (av_add) avail_ff[j_ff] <= avail_ff[j_ff] + rqv_ff[j_ff];
      if (rq_wr) rqv_ff[RB'(req.resource)] <= amt;
      if (wk_load) work_ff[j_ff] <= (j_ff <= mlast) ? WB'(avail_ff[j_ff]) : '0;
      if (wk_add) work_ff[j_ff] <= wsum[WB] ? WORK_MAX : wsum[WB-1:0];
      if (fin_clr) fin_ff <= '0;
      if (fin_set) fin_ff[i_ff] <= 1'b1;
      if (ord_wr) order_ff[cnt_ff[3:0]] <= 4'(i_ff);
   end
endmodule

// ----- hdl/bnk_checker.sv -----
// Port-level checker for the banker unit, bound to the top level.
// Depends on bnk_pkg and the top-level port list.
module bnk_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic       rsp_safe,
   input logic [1:0] rsp_status,
   input logic       rsp_end_of_run
);
   // never accept while a result is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while result pending");

   // a granted verdict is safe; refusals are not
   a_grant_safe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == bnk_pkg::KIND_REQUEST) |->
         (rsp_safe == (rsp_status == bnk_pkg::ST_GRANTED)))
      else $error("verdict safe flag mismatch");

   // a verdict is always a single word
   a_verdict_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == bnk_pkg::KIND_REQUEST) |-> rsp_end_of_run)
      else $error("verdict without end of run");

   // ready returns after the last word leaves
   a_ready_after_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_end_of_run) |=> req_ready)
      else $error("not ready after run end");
endmodule

bind banker_safety_and_request_check bnk_checker u_bnk_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_kind(rsp.kind), .rsp_safe(rsp.safe),
   .rsp_status(rsp.status), .rsp_end_of_run(rsp.end_of_run));
